// ===== rtl/core/hsr_pkg.sv =====
// -----------------------------------------------------------------------------
// hsr_pkg: shared constants for the Heron square root block
// Default fixed-point format, register widths, reset values and the
// configuration port layout.
// -----------------------------------------------------------------------------
`default_nettype none

package hsr_pkg;

	localparam int FRAC_BITS_DEF = 16;
	localparam int INT_BITS_DEF  = 17;

	localparam int ERR_W  = 33;
	localparam int ITER_W = 8;

	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 33;

	localparam logic [ERR_W-1:0]  ERR_RESET  = ERR_W'(1);
	localparam logic [ITER_W-1:0] ITER_RESET = ITER_W'(64);

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_ERROR_LIMIT     = 1'b0,
		REG_ITERATION_LIMIT = 1'b1
	} cfg_reg_t;

endpackage

`default_nettype wire

// ===== rtl/core/hsr_req_if.sv =====
// -----------------------------------------------------------------------------
// hsr_req_if: request channel of the Heron square root block
// Valid/ready handshake carrying one unsigned fixed-point radicand.
// -----------------------------------------------------------------------------
`default_nettype none

interface hsr_req_if #(
	parameter int VAL_W = 33
);
	logic             valid;
	logic             ready;
	logic [VAL_W-1:0] radicand;

	modport source (output valid, output radicand, input ready);
	modport sink   (input valid, input radicand, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/hsr_res_if.sv =====
// -----------------------------------------------------------------------------
// hsr_res_if: result channel of the Heron square root block
// Valid/ready handshake carrying the root, the step count and the limit flag.
// -----------------------------------------------------------------------------
`default_nettype none

interface hsr_res_if #(
	parameter int VAL_W  = 33,
	parameter int STEP_W = 8
);
	logic              valid;
	logic              ready;
	logic [VAL_W-1:0]  root;
	logic [STEP_W-1:0] steps_taken;
	logic              hit_limit;

	modport source (output valid, output root, output steps_taken, output hit_limit,
		input ready);
	modport sink   (input valid, input root, input steps_taken, input hit_limit,
		output ready);
endinterface

`default_nettype wire

// ===== rtl/core/heron_square_root.sv =====
// -----------------------------------------------------------------------------
// heron_square_root: fixed-point square root by Heron's method
// Iterates estimate = (radicand / estimate + estimate) / 2 with one shared
// restoring divider, stopping on a small gap or at the step limit.
// -----------------------------------------------------------------------------
//  channel  dir  handshake        payload
//  req      in   valid/ready      radicand
//  res      out  valid/ready      root, steps_taken, hit_limit
//  cfg      in   cfg_we only      cfg_index, cfg_data
//
//  Default format is Q17.16. Each update step draws one quotient bit a cycle from
//  the shared subtract/compare unit, then makes one update of the estimate.
//  A zero radicand skips the divider and goes straight to emission.
//  req.ready is low while an item is in flight; a result waiting in the output
//  register does not block the next item, only the emission of the following.
//  arst_n clears control state and resets the registers to 1 and 64.
// -----------------------------------------------------------------------------
`default_nettype none

module heron_square_root #(
	parameter int FRAC_BITS = hsr_pkg::FRAC_BITS_DEF,
	parameter int INT_BITS  = hsr_pkg::INT_BITS_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	hsr_req_if.sink                            req,
	hsr_res_if.source                          res,
	input  wire logic                          cfg_we,
	input  wire logic [hsr_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [hsr_pkg::CFG_DATA_W-1:0] cfg_data
);
	import hsr_pkg::*;

	localparam int TOTAL_W = INT_BITS + FRAC_BITS;
	localparam int NUM_W   = TOTAL_W + FRAC_BITS;
	localparam int CNT_W   = $clog2(NUM_W);
	localparam int CMP_W   = (TOTAL_W > ERR_W) ? TOTAL_W : ERR_W;

	localparam logic [TOTAL_W-1:0] VAL_MAX  = {TOTAL_W{1'b1}};
	localparam logic [CNT_W-1:0]   CNT_LAST = CNT_W'(NUM_W - 1);
	localparam logic [CNT_W-1:0]   CNT_OVF  = CNT_W'(FRAC_BITS);

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_DIV  = 4'b0010,
		ST_STEP = 4'b0100,
		ST_EMIT = 4'b1000
	} state_t;

	state_t               state_q;
	logic [ERR_W-1:0]     err_q;
	logic [ITER_W-1:0]    iter_q;
	logic [TOTAL_W-1:0]   rad_q;
	logic [TOTAL_W-1:0]   est_q;
	logic [NUM_W-1:0]     num_q;
	logic [TOTAL_W-1:0]   rem_q;
	logic [TOTAL_W-1:0]   quo_q;
	logic                 ovf_q;
	logic [CNT_W-1:0]     cnt_q;
	logic [ITER_W-1:0]    steps_q;
	logic                 hit_q;
	logic                 res_valid_q;
	logic [TOTAL_W-1:0]   res_root_q;
	logic [ITER_W-1:0]    res_steps_q;
	logic                 res_hit_q;

	logic                 req_fire;
	logic                 emit_fire;
	logic [TOTAL_W:0]     trial;
	logic                 trial_ge;
	logic [TOTAL_W:0]     trial_diff;
	logic [TOTAL_W-1:0]   quo;
	logic [TOTAL_W:0]     sum;
	logic [TOTAL_W-1:0]   nxt;
	logic [TOTAL_W-1:0]   gap;
	logic                 converged;
	logic [ITER_W-1:0]    steps_nxt;
	logic [ITER_W-1:0]    limit;
	logic [TOTAL_W-1:0]   est_first;

	assign req.ready = (state_q == ST_IDLE);
	assign req_fire  = req.valid && req.ready;
	assign emit_fire = (state_q == ST_EMIT) && (!res_valid_q || res.ready);

	assign res.valid       = res_valid_q;
	assign res.root        = res_root_q;
	assign res.steps_taken = res_steps_q;
	assign res.hit_limit   = res_hit_q;

	assign est_first = (req.radicand >> 1) == '0 ? TOTAL_W'(1) : (req.radicand >> 1);

	// shared subtract/compare unit of the restoring divider
	assign trial      = {rem_q, num_q[NUM_W-1]};
	assign trial_diff = trial - {1'b0, est_q};
	assign trial_ge   = !trial_diff[TOTAL_W] || trial[TOTAL_W];

	assign quo       = ovf_q ? VAL_MAX : quo_q;
	assign sum       = {1'b0, quo} + {1'b0, est_q};
	assign nxt       = (sum[TOTAL_W:1] == '0) ? TOTAL_W'(1) : sum[TOTAL_W:1];
	assign gap       = nxt - quo;
	assign converged = (nxt < quo) || (CMP_W'(gap) < CMP_W'(err_q));
	assign steps_nxt = steps_q + ITER_W'(1);
	assign limit     = (iter_q == '0) ? ITER_W'(1) : iter_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			err_q  <= ERR_RESET;
			iter_q <= ITER_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_ERROR_LIMIT:     err_q  <= cfg_data[ERR_W-1:0];
				REG_ITERATION_LIMIT: iter_q <= cfg_data[ITER_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			case (state_q)
				ST_IDLE: if (req_fire) begin
					state_q <= (req.radicand == '0) ? ST_EMIT : ST_DIV;
				end
				ST_DIV: if (cnt_q == CNT_LAST) begin
					state_q <= ST_STEP;
				end
				ST_STEP: begin
					if (converged || steps_nxt >= limit) state_q <= ST_EMIT;
					else state_q <= ST_DIV;
				end
				ST_EMIT: if (emit_fire) begin
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: if (req_fire) begin
				rad_q   <= req.radicand;
				est_q   <= (req.radicand == '0) ? '0 : est_first;
				num_q   <= {req.radicand, {FRAC_BITS{1'b0}}};
				rem_q   <= '0;
				ovf_q   <= 1'b0;
				cnt_q   <= '0;
				steps_q <= '0;
				hit_q   <= 1'b0;
			end
			ST_DIV: begin
				num_q <= num_q << 1;
				rem_q <= trial_ge ? trial_diff[TOTAL_W-1:0] : trial[TOTAL_W-1:0];
				quo_q <= {quo_q[TOTAL_W-2:0], trial_ge};
				if (trial_ge && cnt_q < CNT_OVF) ovf_q <= 1'b1;
				cnt_q <= cnt_q + CNT_W'(1);
			end
			ST_STEP: begin
				est_q   <= nxt;
				steps_q <= steps_nxt;
				hit_q   <= !converged && (steps_nxt >= limit);
				num_q   <= {rad_q, {FRAC_BITS{1'b0}}};
				rem_q   <= '0;
				ovf_q   <= 1'b0;
				cnt_q   <= '0;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (emit_fire) begin
			res_valid_q <= 1'b1;
		end else if (res.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit_fire) begin
			res_root_q  <= est_q;
			res_steps_q <= steps_q;
			res_hit_q   <= hit_q;
		end
	end

	a_rem_below_divisor: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV) |-> (rem_q < est_q))
		else $error("divider remainder not below divisor");

	a_divisor_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV) |-> (est_q != '0))
		else $error("zero divisor in divider");

	a_nonzero_starts_div: assert property (@(posedge clk) disable iff (!arst_n)
		(req_fire && req.radicand != '0) |=> (state_q == ST_DIV))
		else $error("nonzero radicand did not start a division");

	a_hit_at_limit: assert property (@(posedge clk) disable iff (!arst_n)
		(emit_fire && hit_q) |-> (steps_q == limit))
		else $error("limit flag raised off the step limit");

	a_emit_no_loss: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid_q && !res.ready) |=> res_valid_q)
		else $error("pending result dropped");

endmodule

`default_nettype wire

// ===== tb/heron_square_root_test.sv =====
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// heron_square_root_test: self-checking bench for the Heron square root block
// Drives radicands through the request channel under several register
// settings and handshake idling patterns, predicts root, step count and limit
// flag for each accepted item, and compares every result in arrival order.
// -----------------------------------------------------------------------------
module heron_square_root_test;
	import hsr_pkg::*;

	localparam int VAL_W = INT_BITS_DEF + FRAC_BITS_DEF;
	localparam logic [63:0] VAL_MAX = (64'd1 << VAL_W) - 64'd1;
	localparam int STEP_CYCLES = INT_BITS_DEF + 2 * FRAC_BITS_DEF + 1;
	localparam longint CYCLE_LIMIT = 60_000_000;
	localparam int HOLD_CYCLES = 3000;

	localparam logic [VAL_W-1:0] CORNER_RADICANDS [19] = '{
		33'd0, 33'd1, 33'd2, 33'd3, 33'd255, 33'h0_0000_8000, 33'h0_0000_FFFF,
		33'h0_0001_0000, 33'h0_0002_0000, 33'h0_0004_0000, 33'h0_0064_0000,
		33'h1_8610_0000, 33'd6553600000, 33'h1_FFFF_FFFF, 33'h1_0000_0000,
		33'h0_AAAA_AAAA, 33'h1_5555_5555, 33'h0_FFFF_FFFF, 33'd0
	};

	typedef enum int {PRESS_NONE, PRESS_HOLD, PRESS_PAUSE} pressure_t;

	typedef struct packed {
		logic [VAL_W-1:0]  root;
		logic [ITER_W-1:0] steps;
		logic              hit;
	} root_result_t;

	class root_scoreboard;
		logic [ERR_W-1:0]  err_lim;
		logic [ITER_W-1:0] iter_lim;
		root_result_t      pending[$];
		int                errors;

		function void clear_regs();
			err_lim = ERR_RESET;
			iter_lim = ITER_RESET;
			errors = 0;
		endfunction

		function void write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] data);
			if (idx == REG_ERROR_LIMIT) begin
				err_lim = data[ERR_W-1:0];
			end else begin
				iter_lim = data[ITER_W-1:0];
			end
		endfunction

		function root_result_t predict_root(logic [VAL_W-1:0] rad);
			root_result_t r;
			logic [63:0]  est;
			logic [63:0]  quo;
			logic [63:0]  nxt;
			int           limit;
			int           steps;
			longint       gap;
			bit           done;
			r = '0;
			if (rad == '0)
				return r;
			limit = (iter_lim == '0) ? 1 : int'(iter_lim);
			est = 64'(rad) >> 1;
			if (est == 0)
				est = 1;
			steps = 0;
			done = 1'b0;
			while (!done) begin
				quo = (64'(rad) << FRAC_BITS_DEF) / est;
				if (quo > VAL_MAX)
					quo = VAL_MAX;
				nxt = (quo + est) >> 1;
				if (nxt == 0)
					nxt = 1;
				gap = longint'(nxt) - longint'(quo);
				est = nxt;
				steps++;
				if (gap < longint'(64'(err_lim))) begin
					done = 1'b1;
				end else if (steps >= limit) begin
					r.hit = 1'b1;
					done = 1'b1;
				end
			end
			r.root = est[VAL_W-1:0];
			r.steps = steps[ITER_W-1:0];
			return r;
		endfunction

		function void note_radicand(logic [VAL_W-1:0] rad);
			pending.push_back(predict_root(rad));
		endfunction

		function void check_result(root_result_t got);
			root_result_t want;
			if (pending.size() == 0) begin
				$display("%0t: unexpected result root %h steps %0d hit %0b", $time,
					got.root, got.steps, got.hit);
				errors++;
				return;
			end
			want = pending.pop_front();
			if (got.root !== want.root) begin
				$display("%0t: root expected %h, got %h", $time, want.root, got.root);
				errors++;
			end
			if (got.steps !== want.steps) begin
				$display("%0t: steps_taken expected %0d, got %0d", $time, want.steps, got.steps);
				errors++;
			end
			if (got.hit !== want.hit) begin
				$display("%0t: hit_limit expected %0b, got %0b", $time, want.hit, got.hit);
				errors++;
			end
		endfunction
	endclass

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	int                    send_idle = 0;
	int                    recv_stall = 0;
	bit                    hold_req = 1'b0;
	longint                cycles = 0;
	root_scoreboard        sb = new;

	hsr_req_if #(.VAL_W(VAL_W)) req_ch ();
	hsr_res_if #(.VAL_W(VAL_W), .STEP_W(ITER_W)) res_ch ();

	heron_square_root dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req_ch),
		.res       (res_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #2 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("heron_square_root_test NOT OK");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n === 1'b1 && res_ch.valid === 1'b1 && res_ch.ready === 1'b1)
			sb.check_result({res_ch.root, res_ch.steps_taken, res_ch.hit_limit});
	end

	initial begin
		int k;
		res_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				res_ch.ready <= 1'b0;
				for (k = 1; k < HOLD_CYCLES; k++)
					@(negedge clk);
			end else begin
				res_ch.ready <= ($urandom_range(0, 99) >= recv_stall);
			end
		end
	end

	function automatic logic [VAL_W-1:0] pick_radicand();
		logic [VAL_W-1:0] v;
		int               k;
		case ($urandom_range(0, 4))
			0: v = VAL_W'($urandom_range(0, 300));
			1: begin
				k = $urandom_range(0, 316);
				v = VAL_W'(k * k) << FRAC_BITS_DEF;
			end
			2: v = {1'($urandom_range(0, 1)), 32'($urandom())};
			3: v = {1'($urandom_range(0, 1)), 32'($urandom())} >> $urandom_range(0, 32);
			default: v = VAL_W'($urandom_range(0, 100000)) << FRAC_BITS_DEF;
		endcase
		return v;
	endfunction

	task automatic send_radicand(input logic [VAL_W-1:0] rad);
		@(negedge clk);
		while ($urandom_range(0, 99) < send_idle) begin
			req_ch.valid <= 1'b0;
			@(negedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.radicand <= rad;
		do @(posedge clk); while (req_ch.ready !== 1'b1);
		sb.note_radicand(rad);
	endtask

	task automatic drain();
		@(negedge clk);
		req_ch.valid <= 1'b0;
		while (sb.pending.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] data);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(negedge clk);
		cfg_we <= 1'b0;
		sb.write_reg(idx, data);
	endtask

	task automatic run_phase(input logic [CFG_DATA_W-1:0] err, input logic [CFG_DATA_W-1:0] iter,
		input int s_idle, input int r_stall, input int count, input pressure_t press);
		int i;
		drain();
		write_reg(REG_ERROR_LIMIT, err);
		write_reg(REG_ITERATION_LIMIT, iter);
		send_idle = s_idle;
		recv_stall = r_stall;
		if (press == PRESS_HOLD)
			hold_req = 1'b1;
		for (i = 0; i < count; i++) begin
			if (press == PRESS_PAUSE && i == count / 2)
				drain();
			send_radicand(pick_radicand());
		end
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = REG_ERROR_LIMIT;
		cfg_data = '0;
		req_ch.valid = 1'b0;
		req_ch.radicand = '0;
		sb.clear_regs();
		repeat (12) @(negedge clk);
		arst_n <= 1'b1;

		foreach (CORNER_RADICANDS[i])
			send_radicand(CORNER_RADICANDS[i]);

		run_phase(33'd1, {25'h0AB_CDEF, 8'd64}, 0, 0, 300, PRESS_NONE);
		run_phase(33'd0, 33'd255, 22, 22, 12, PRESS_NONE);
		run_phase(33'd6553600000, 33'd1, 66, 0, 150, PRESS_NONE);
		run_phase(33'd0, 33'd0, 0, 66, 100, PRESS_NONE);
		run_phase(CFG_DATA_W'($urandom_range(0, 65535)), CFG_DATA_W'($urandom_range(1, 40)),
			22, 22, 300, PRESS_PAUSE);
		run_phase(33'd1, 33'd64, 0, 66, 300, PRESS_HOLD);
		run_phase(CFG_DATA_W'($urandom_range(0, 655360)), CFG_DATA_W'($urandom_range(5, 255)),
			66, 0, 250, PRESS_NONE);
		run_phase(33'h1_FFFF_FFFF, {25'h1FF_FFFF, 8'hFF}, 0, 0, 80, PRESS_NONE);

		drain();
		repeat (2 * STEP_CYCLES) @(posedge clk);
		if (sb.errors == 0 && sb.pending.size() == 0) begin
			$display("heron_square_root_test OK");
		end else begin
			$display("heron_square_root_test NOT OK");
		end
		$finish;
	end
endmodule

// ===== heron_square_root.f =====
rtl/core/hsr_pkg.sv
rtl/core/hsr_req_if.sv
rtl/core/hsr_res_if.sv
rtl/core/heron_square_root.sv
tb/heron_square_root_test.sv
